[rtl/bbsk_pkg.sv]
package bbsk_pkg;

  // channel width and derived datapath widths
  localparam int CH_W  = 16;
  localparam int SUM_W = CH_W + 2;
  localparam int S_W   = CH_W + 1;
  localparam int MUL_W = 2 * S_W;
  localparam int DEN_W = 2 * CH_W + 2;
  localparam int NUM_W = CH_W + MUL_W;

  // pipeline latency
  localparam int FRONT_LAT = 5;
  localparam int DIV_LAT   = CH_W + 1;
  localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT + 1;

  localparam logic [CH_W-1:0] CH_MAX     = '1;
  localparam logic [CH_W-1:0] THRESH_RST = 16'd4096;
  localparam logic [CH_W-1:0] KNEE_RST   = 16'd2458;

  typedef enum logic [1:0] {
    CFG_THRESH = 2'd0,
    CFG_KNEE   = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [CH_W-1:0] p00_red;
    logic [CH_W-1:0] p00_green;
    logic [CH_W-1:0] p00_blue;
    logic [CH_W-1:0] p01_red;
    logic [CH_W-1:0] p01_green;
    logic [CH_W-1:0] p01_blue;
    logic [CH_W-1:0] p10_red;
    logic [CH_W-1:0] p10_green;
    logic [CH_W-1:0] p10_blue;
    logic [CH_W-1:0] p11_red;
    logic [CH_W-1:0] p11_green;
    logic [CH_W-1:0] p11_blue;
  } bbsk_pix_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
  } bbsk_res_t;

  typedef struct packed {
    logic [CH_W-1:0] thresh;
    logic [CH_W-1:0] knee;
  } bbsk_cfg_t;

  // per-channel numerator and shared denominator handed to the dividers
  typedef struct packed {
    logic [NUM_W-1:0] num_r;
    logic [NUM_W-1:0] num_g;
    logic [NUM_W-1:0] num_b;
    logic [DEN_W-1:0] den;
  } bbsk_mid_t;

endpackage

[rtl/bloom_bright_pass_soft_knee_core.sv]
// Channel   Direction  Handshake                   Payload
// command   in         start / busy                pix_i      (bbsk_pix_t)
// result    out        res_valid_o strobe          res_o      (bbsk_res_t)
// config    in         cfg_valid_i / cfg_ready_o   cfg_idx_i, cfg_data_i
//
// One 2x2 block is taken every cycle; busy stays low.
// The pipeline has five front stages (average, knee, products, select,
// scale), a 17-stage restoring divider per channel, and the output register.
// Reset clears the valid pipe and loads threshold 1.0 and knee 0.6.
// Results are shown for one cycle with no back pressure, so nothing stalls.
module bloom_bright_pass_soft_knee_core import bbsk_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  bbsk_pix_t       pix_i,
  output logic            res_valid_o,
  output bbsk_res_t       res_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CH_W-1:0] cfg_data_i
);

  bbsk_cfg_t          cfg_q;
  logic               front_vld;
  bbsk_mid_t          mid;
  logic [DIV_LAT-1:0] dvld_q;
  logic [CH_W-1:0]    quo_r, quo_g, quo_b;
  logic               res_valid_q;
  bbsk_res_t          res_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thresh <= THRESH_RST;
      cfg_q.knee   <= KNEE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      // drop writes to unknown indexes
      if (cfg_idx_i == CFG_THRESH) begin
        cfg_q.thresh <= cfg_data_i;
      end else if (cfg_idx_i == CFG_KNEE) begin
        cfg_q.knee <= cfg_data_i;
      end
    end
  end

  bbsk_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .pix_i   (pix_i),
    .cfg_i   (cfg_q),
    .valid_o (front_vld),
    .mid_o   (mid)
  );

  bbsk_div u_div_r (.clk_i(clk_i), .num_i(mid.num_r), .den_i(mid.den), .quo_o(quo_r));
  bbsk_div u_div_g (.clk_i(clk_i), .num_i(mid.num_g), .den_i(mid.den), .quo_o(quo_g));
  bbsk_div u_div_b (.clk_i(clk_i), .num_i(mid.num_b), .den_i(mid.den), .quo_o(quo_b));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      dvld_q      <= {dvld_q[DIV_LAT-2:0], front_vld};
      res_valid_q <= dvld_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.out_red   <= quo_r;
    res_q.out_green <= quo_g;
    res_q.out_blue  <= quo_b;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  // every result word goes back to an accepted block
  a_res_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start && !busy, PIPE_LAT))
    else $error("result word without a matching command");

  // a black block gives a black result
  a_black_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && $past(pix_i == '0, PIPE_LAT)) |-> (res_o == '0))
    else $error("black block gave a nonzero result word");
`endif

endmodule

[rtl/bbsk_front.sv]
module bbsk_front import bbsk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  bbsk_pix_t pix_i,
  input  bbsk_cfg_t cfg_i,
  output logic      valid_o,
  output bbsk_mid_t mid_o
);

  logic [FRONT_LAT-1:0] vld_q;

  logic [SUM_W-1:0] sum_r, sum_g, sum_b;
  logic [CH_W-1:0]  avg1_d [3];
  logic [CH_W-1:0]  avg1_q [3];

  logic [CH_W-1:0]         x_val;
  logic [CH_W-1:0]         knee_eff;
  logic signed [SUM_W-1:0] s_raw;
  logic [S_W-1:0]          knee_x2;
  logic [S_W-1:0]          knee_s_d, knee_s_q;
  logic [CH_W-1:0]         lin_d, lin_q;
  logic [CH_W-1:0]         xd_d, xd_q;
  logic [CH_W-1:0]         avg2_q [3];

  logic [MUL_W-1:0]  sq_d, sq_q;
  logic [2*CH_W-1:0] klin, kxd;
  logic [MUL_W-1:0]  kl4_q;
  logic [DEN_W-1:0]  den3_q;
  logic [CH_W-1:0]   avg3_q [3];

  logic [MUL_W-1:0] m_d, m_q;
  logic [DEN_W-1:0] den4_q;
  logic [CH_W-1:0]  avg4_q [3];

  logic [NUM_W-1:0] num_q [3];
  logic [DEN_W-1:0] den5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FRONT_LAT-2:0], valid_i};
    end
  end

  // stage 1: per-channel block average
  always_comb begin
    sum_r = SUM_W'(pix_i.p00_red) + SUM_W'(pix_i.p01_red)
          + SUM_W'(pix_i.p10_red) + SUM_W'(pix_i.p11_red);
    sum_g = SUM_W'(pix_i.p00_green) + SUM_W'(pix_i.p01_green)
          + SUM_W'(pix_i.p10_green) + SUM_W'(pix_i.p11_green);
    sum_b = SUM_W'(pix_i.p00_blue) + SUM_W'(pix_i.p01_blue)
          + SUM_W'(pix_i.p10_blue) + SUM_W'(pix_i.p11_blue);
    avg1_d[0] = sum_r[SUM_W-1:2];
    avg1_d[1] = sum_g[SUM_W-1:2];
    avg1_d[2] = sum_b[SUM_W-1:2];
  end

  // stage 2: brightness, knee curve input and linear term
  always_comb begin
    x_val = avg1_q[0];
    if (avg1_q[1] > x_val) begin
      x_val = avg1_q[1];
    end
    if (avg1_q[2] > x_val) begin
      x_val = avg1_q[2];
    end
    knee_eff = (cfg_i.knee == '0) ? CH_W'(1) : cfg_i.knee;
    knee_x2  = {knee_eff, 1'b0};
    s_raw    = $signed(SUM_W'(x_val)) + $signed(SUM_W'(knee_eff))
             - $signed(SUM_W'(cfg_i.thresh));
    if (s_raw[SUM_W-1]) begin
      knee_s_d = '0;
    end else if (s_raw[S_W-1:0] > knee_x2) begin
      knee_s_d = knee_x2;
    end else begin
      knee_s_d = s_raw[S_W-1:0];
    end
    lin_d = (x_val > cfg_i.thresh) ? (x_val - cfg_i.thresh) : '0;
    xd_d  = (x_val == '0) ? CH_W'(1) : x_val;
  end

  // stage 3: products
  always_comb begin
    sq_d = knee_s_q * knee_s_q;
    klin = ((cfg_i.knee == '0) ? CH_W'(1) : cfg_i.knee) * lin_q;
    kxd  = ((cfg_i.knee == '0) ? CH_W'(1) : cfg_i.knee) * xd_q;
  end

  // stage 4: pick the larger of soft and linear term, both over 4k
  always_comb begin
    m_d = (sq_q > kl4_q) ? sq_q : kl4_q;
  end

  always_ff @(posedge clk_i) begin
    avg1_q   <= avg1_d;
    avg2_q   <= avg1_q;
    knee_s_q <= knee_s_d;
    lin_q    <= lin_d;
    xd_q     <= xd_d;
    avg3_q   <= avg2_q;
    sq_q     <= sq_d;
    kl4_q    <= {klin, 2'b00};
    den3_q   <= {kxd, 2'b00};
    avg4_q   <= avg3_q;
    m_q      <= m_d;
    den4_q   <= den3_q;
    num_q[0] <= avg4_q[0] * m_q;
    num_q[1] <= avg4_q[1] * m_q;
    num_q[2] <= avg4_q[2] * m_q;
    den5_q   <= den4_q;
  end

  assign valid_o     = vld_q[FRONT_LAT-1];
  assign mid_o.num_r = num_q[0];
  assign mid_o.num_g = num_q[1];
  assign mid_o.num_b = num_q[2];
  assign mid_o.den   = den5_q;

endmodule

[rtl/bbsk_div.sv]
module bbsk_div import bbsk_pkg::*; (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [CH_W-1:0]  quo_o
);

  logic [NUM_W-1:0] rem_d [DIV_LAT];
  logic [NUM_W-1:0] rem_q [DIV_LAT];
  logic [DEN_W-1:0] den_d [DIV_LAT];
  logic [DEN_W-1:0] den_q [DIV_LAT];
  logic [CH_W-1:0]  quo_d [DIV_LAT];
  logic [CH_W-1:0]  quo_q [DIV_LAT];
  logic             ovf_d [DIV_LAT];
  logic             ovf_q [DIV_LAT];

  // first stage flags a quotient past the channel range, then one
  // restoring step per stage from the top quotient bit down
  always_comb begin
    logic [NUM_W-1:0] cand;
    rem_d[0] = num_i;
    den_d[0] = den_i;
    quo_d[0] = '0;
    ovf_d[0] = num_i >= (NUM_W'(den_i) << CH_W);
    for (int j = 1; j < DIV_LAT; j++) begin
      cand     = NUM_W'(den_q[j-1]) << (CH_W - j);
      den_d[j] = den_q[j-1];
      ovf_d[j] = ovf_q[j-1];
      quo_d[j] = quo_q[j-1];
      if (rem_q[j-1] >= cand) begin
        rem_d[j]          = rem_q[j-1] - cand;
        quo_d[j][CH_W-j]  = 1'b1;
      end else begin
        rem_d[j] = rem_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign quo_o = ovf_q[DIV_LAT-1] ? CH_MAX : quo_q[DIV_LAT-1];

endmodule

[verif/bbsk_checker.sv]
`timescale 1ns / 1ps

module bbsk_checker import bbsk_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  bbsk_pix_t       pix_i,
  input  logic            res_valid_i,
  input  bbsk_res_t       res_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CH_W-1:0] cfg_data_i,
  output int              err_cnt_o,
  output int              pend_o
);

  logic [CH_W-1:0] thresh_q;
  logic [CH_W-1:0] knee_q;
  bbsk_res_t       glow_due_q [$];

  // Weighted half-resolution color of one 2x2 block under the given threshold and knee.
  function automatic bbsk_res_t bright_pass(bbsk_pix_t px, logic [CH_W-1:0] thr,
                                            logic [CH_W-1:0] knee);
    logic [63:0]     avg [3];
    logic [63:0]     sum;
    logic [63:0]     peak;
    logic [63:0]     xd;
    logic [63:0]     k;
    logic [63:0]     s2;
    logic [63:0]     lin;
    logic [63:0]     knee_term;
    logic [63:0]     ramp_term;
    logic [63:0]     best;
    longint          s;
    logic [CH_W-1:0] chan [3];
    bbsk_res_t       r;
    peak = '0;
    for (int c = 0; c < 3; c++) begin
      sum = 64'(px[(11-c)*CH_W +: CH_W]) + 64'(px[(8-c)*CH_W +: CH_W])
          + 64'(px[(5-c)*CH_W +: CH_W]) + 64'(px[(2-c)*CH_W +: CH_W]);
      avg[c] = sum >> 2;
      if (avg[c] > peak) peak = avg[c];
    end
    // a knee of zero acts as one LSB
    k = (knee == '0) ? 64'd1 : 64'(knee);
    s = longint'(peak) - longint'(thr) + longint'(k);
    if (s < 0) s = 0;
    if (s > 2 * longint'(k)) s = 2 * longint'(k);
    s2 = 64'(s) * 64'(s);
    xd = (peak == '0) ? 64'd1 : peak;
    lin = (peak > 64'(thr)) ? peak - 64'(thr) : 64'd0;
    for (int c = 0; c < 3; c++) begin
      knee_term = (avg[c] * s2) / (64'd4 * k * xd);
      ramp_term = (avg[c] * lin) / xd;
      best = (knee_term > ramp_term) ? knee_term : ramp_term;
      chan[c] = (best > 64'(CH_MAX)) ? CH_MAX : best[CH_W-1:0];
    end
    r.out_red   = chan[0];
    r.out_green = chan[1];
    r.out_blue  = chan[2];
    return r;
  endfunction

  task automatic flag(string what, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
    if (err_cnt_o < 10)
      $display("%0t checker: %s expected %0d, got %0d", $time, what, want, got);
    err_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bbsk_res_t want;
    if (!rst_ni) begin
      thresh_q = THRESH_RST;
      knee_q   = KNEE_RST;
      glow_due_q.delete();
      pend_o    = 0;
      err_cnt_o = 0;
    end else begin
      if (start_i && !busy_i)
        glow_due_q.push_back(bright_pass(pix_i, thresh_q, knee_q));
      if (res_valid_i) begin
        if (glow_due_q.size() == 0) begin
          if (err_cnt_o < 10)
            $display("%0t checker: result word with nothing outstanding", $time);
          err_cnt_o++;
        end else begin
          want = glow_due_q.pop_front();
          if (res_i.out_red !== want.out_red)
            flag("out_red", want.out_red, res_i.out_red);
          if (res_i.out_green !== want.out_green)
            flag("out_green", want.out_green, res_i.out_green);
          if (res_i.out_blue !== want.out_blue)
            flag("out_blue", want.out_blue, res_i.out_blue);
        end
      end
      // indexes outside the register map are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_i)
          CFG_THRESH: thresh_q = cfg_data_i;
          CFG_KNEE:   knee_q   = cfg_data_i;
          default:    ;
        endcase
      end
      pend_o = glow_due_q.size();
    end
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import bbsk_pkg::*;

  localparam logic [1:0] CFG_IDX_VOID_LO = 2'd2;
  localparam logic [1:0] CFG_IDX_VOID_HI = 2'd3;
  localparam int PHASES      = 9;
  localparam int BLOCKS_EACH = 80;
  localparam int IDLE_LIMIT  = 4000;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  bbsk_pix_t       pix_i;
  logic            res_valid_o;
  bbsk_res_t       res_o;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [1:0]      cfg_idx_i;
  logic [CH_W-1:0] cfg_data_i;
  int              err_cnt;
  int              pend;
  int              idle_run = 0;
  logic [CH_W-1:0] cur_thr;
  logic [CH_W-1:0] cur_knee;
  logic [CH_W-1:0] plan_thr  [PHASES];
  logic [CH_W-1:0] plan_knee [PHASES];

  bloom_bright_pass_soft_knee_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pix_i       (pix_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  bbsk_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .pix_i       (pix_i),
    .res_valid_i (res_valid_o),
    .res_i       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .err_cnt_o   (err_cnt),
    .pend_o      (pend)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bbsk_pix_t gray(int r, int g, int b);
    bbsk_pix_t px;
    for (int p = 0; p < 4; p++) begin
      px[(11-3*p)*CH_W +: CH_W] = CH_W'(r);
      px[(10-3*p)*CH_W +: CH_W] = CH_W'(g);
      px[(9-3*p)*CH_W +: CH_W]  = CH_W'(b);
    end
    return px;
  endfunction

  // Nearly half the blocks have brightness around the knee; the rest are full-range,
  // near-black and saturated-extreme blocks.
  function automatic bbsk_pix_t random_block(logic [CH_W-1:0] thr, logic [CH_W-1:0] knee);
    bbsk_pix_t px;
    int        lvl [3];
    int        aim;
    int        hot;
    int        mode;
    int        v;
    mode = $urandom_range(0, 99);
    hot  = $urandom_range(0, 2);
    aim  = int'(thr) - 2 * int'(knee) - 2 + int'($urandom_range(0, 4 * int'(knee) + 4));
    for (int c = 0; c < 3; c++)
      lvl[c] = (c == hot) ? aim : aim * int'($urandom_range(0, 100)) / 100;
    for (int i = 0; i < 12; i++) begin
      if (mode < 45) begin
        v = lvl[i % 3] + int'($urandom_range(0, 6)) - 3;
      end else if (mode < 75) begin
        v = int'($urandom_range(0, 65535));
      end else if (mode < 90) begin
        v = int'($urandom_range(0, 64));
      end else begin
        case ($urandom_range(0, 3))
          0:       v = 0;
          1:       v = 1;
          2:       v = 65534;
          default: v = 65535;
        endcase
      end
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      px[(11-i)*CH_W +: CH_W] = CH_W'(v);
    end
    return px;
  endfunction

  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Leaves start high so back-to-back words need no second assignment.
  task automatic send_block(bbsk_pix_t px, int gap);
    start <= 1'b1;
    pix_i <= px;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      pix_i <= bbsk_pix_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the command side until every outstanding word has come out.
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk_i); while (pend != 0);
    @(posedge clk_i);
  endtask

  task automatic cfg_put(logic [1:0] idx, logic [CH_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic program_knee(logic [CH_W-1:0] thr, logic [CH_W-1:0] knee, bit junk);
    if (junk) begin
      cfg_put(CFG_IDX_VOID_LO, CH_W'($urandom));
      cfg_put(CFG_IDX_VOID_HI, CH_W'($urandom));
    end
    cfg_put(CFG_THRESH, thr);
    cfg_put(CFG_KNEE, knee);
    cfg_valid_i <= 1'b0;
    cur_thr  = thr;
    cur_knee = knee;
  endtask

  initial begin
    bit steady;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    pix_i       <= '0;
    cfg_valid_i <= 1'b0;
    cfg_idx_i   <= CFG_THRESH;
    cfg_data_i  <= '0;
    cur_thr  = THRESH_RST;
    cur_knee = KNEE_RST;
    plan_thr  = '{THRESH_RST, 16'd0, 16'hFFFF, 16'd0, 16'd4096, 16'd32768,
                  CH_W'($urandom), CH_W'($urandom_range(0, 2048)), CH_W'($urandom)};
    plan_knee = '{KNEE_RST, 16'hFFFF, 16'd1, 16'd0, 16'd1, 16'hFFFF,
                  CH_W'($urandom_range(1, 65535)), CH_W'($urandom_range(1, 256)),
                  CH_W'($urandom)};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < PHASES; ph++) begin
      // the first phase runs on the reset register values
      if (ph > 0) begin
        settle();
        program_knee(plan_thr[ph], plan_knee[ph], ph == 3);
      end
      case (ph)
        0: begin
          send_block(gray(0, 0, 0), pick_gap(1'b0));
          send_block(gray(65535, 65535, 65535), pick_gap(1'b0));
          send_block(gray(1637, 1637, 1637), pick_gap(1'b0));
          send_block(gray(1638, 1638, 1638), pick_gap(1'b0));
          send_block(gray(1639, 1639, 1639), pick_gap(1'b0));
          send_block(gray(4096, 4096, 4096), pick_gap(1'b0));
          send_block(gray(4097, 4097, 4097), pick_gap(1'b0));
          send_block(gray(6554, 6554, 6554), pick_gap(1'b0));
          send_block(gray(6555, 6555, 6555), pick_gap(1'b0));
          send_block(gray(65535, 0, 0), pick_gap(1'b0));
          send_block(gray(0, 65535, 0), pick_gap(1'b0));
          send_block(gray(0, 0, 65535), pick_gap(1'b0));
          send_block(gray(20000, 100, 5000), pick_gap(1'b0));
          send_block(bbsk_pix_t'({16'd3, 16'd0, 16'd1, 16'd0, 16'd2, 16'd0,
                                  16'd0, 16'd0, 16'd3, 16'd1, 16'd1, 16'd65535}),
                     pick_gap(1'b0));
        end
        1: begin
          // tiny brightness under a wide knee pushes the weight above one
          send_block(gray(1, 1, 1), pick_gap(1'b0));
          send_block(gray(1, 0, 0), pick_gap(1'b0));
          send_block(gray(100, 50, 0), pick_gap(1'b0));
          send_block(gray(0, 0, 0), pick_gap(1'b0));
        end
        2: begin
          send_block(gray(65535, 65535, 65535), pick_gap(1'b0));
          send_block(gray(65534, 65534, 0), pick_gap(1'b0));
        end
        3: begin
          send_block(gray(0, 0, 0), pick_gap(1'b0));
          send_block(gray(1, 2, 3), pick_gap(1'b0));
          send_block(gray(65535, 1, 0), pick_gap(1'b0));
        end
        default: ;
      endcase
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < BLOCKS_EACH; n++) begin
        if ($urandom_range(0, 99) == 0) settle();
        send_block(random_block(cur_thr, cur_knee), pick_gap(steady));
      end
    end

    settle();
    repeat (PIPE_LAT + 8) @(posedge clk_i);
    if (err_cnt == 0 && pend == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Count cycles in which no word moves on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_run <= 0;
    end else if (idle_run >= IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

endmodule
